// File: sv/srq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted request queue package
// Shared depth constants, action and status codes, and the cell control type.
// ----------------------------------------------------------------------------
package srq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int KEY_W       = 64;
   localparam int TAG_W       = 16;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      ACT_INSERT = 1'b0,
      ACT_TAKE   = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_FULL     = 2'd1,
      ST_TAKEN    = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   // Per-cycle command broadcast to every cell of the chain.
   typedef struct packed {
      logic insert;
      logic take;
   } srq_ctrl_type;

endpackage

// File: sv/srq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted request queue cell
// One queue slot: compares its key with the incoming key and either holds,
// shifts from its left neighbor, loads the new request or shifts from the right.
// ----------------------------------------------------------------------------
module srq_cell
   import srq_pkg::*;
(
   input  logic                     clock,
   input  srq_ctrl_type             ctrl,
   input  logic                     occupied,
   input  logic signed [KEY_W-1:0]  new_key,
   input  logic        [TAG_W-1:0]  new_tag,
   input  logic                     left_place,
   input  logic signed [KEY_W-1:0]  left_key,
   input  logic        [TAG_W-1:0]  left_tag,
   input  logic signed [KEY_W-1:0]  right_key,
   input  logic        [TAG_W-1:0]  right_tag,
   output logic                     place,
   output logic signed [KEY_W-1:0]  key_ff,
   output logic        [TAG_W-1:0]  tag_ff
);

   logic signed [KEY_W-1:0] key_in;
   logic        [TAG_W-1:0] tag_in;

   // An empty slot, or one whose key is strictly greater, lies behind the
   // insertion point; equal keys stay ahead so that ties leave in order.
   assign place = !occupied || (key_ff > new_key);

   always_comb begin
      key_in = key_ff;
      tag_in = tag_ff;
      if (ctrl.take) begin
         key_in = right_key;
         tag_in = right_tag;
      end else if (ctrl.insert && place) begin
         if (left_place) begin
            key_in = left_key;
            tag_in = left_tag;
         end else begin
            key_in = new_key;
            tag_in = new_tag;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

endmodule

// File: sv/sorted_request_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted request queue
// Bounded queue of requests kept in ascending signed key order, built as a
// chain of cells that compare and shift in parallel.
// ----------------------------------------------------------------------------
// Result: a request taken at a clock edge gives its result strobe in the
// following cycle.
// Throughput: one request per cycle; every cell compares against the new key
// in parallel and the whole chain shifts in that same cycle, so busy stays low.
// Reset: synchronous, active high; it empties the queue and clears the strobe.
// The receiver cannot stall: each result is shown for exactly one cycle.
module sorted_request_queue_top
   import srq_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_action,
   input  logic signed [KEY_W-1:0]   req_order_key,
   input  logic        [TAG_W-1:0]   req_request_tag,
   output logic                      rsp_valid,
   output logic        [1:0]         rsp_status,
   output logic signed [KEY_W-1:0]   rsp_head_key,
   output logic        [TAG_W-1:0]   rsp_head_tag,
   output logic        [COUNT_W-1:0] rsp_fill_level
);

   // The chain finishes every request as it arrives, so it never stalls
   // the requester.
   assign busy = 1'b0;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff;
   status_type         status_ff, status_in;
   logic signed [KEY_W-1:0] head_key_ff, head_key_in;
   logic        [TAG_W-1:0] head_tag_ff, head_tag_in;

   logic                    is_full, is_empty, accept;
   srq_ctrl_type            ctrl;

   logic                    place    [QUEUE_DEPTH];
   logic signed [KEY_W-1:0] cell_key [QUEUE_DEPTH];
   logic        [TAG_W-1:0] cell_tag [QUEUE_DEPTH];

   assign accept   = start && !busy;
   assign is_full  = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign is_empty = (count_ff == '0);

   // The inserted request is refused when the queue is full, and a take on
   // an empty queue leaves the chain untouched.
   assign ctrl.insert = accept && (action_type'(req_action) == ACT_INSERT) && !is_full;
   assign ctrl.take   = accept && (action_type'(req_action) == ACT_TAKE) && !is_empty;

   // Cell 0 is the head. Occupancy follows from the fill count: the valid
   // entries always form a prefix of the chain.
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                    occ;
      logic                    lplace;
      logic signed [KEY_W-1:0] lkey, rkey;
      logic        [TAG_W-1:0] ltag, rtag;

      assign occ = (count_ff > COUNT_W'(i));

      if (i == 0) begin : g_first
         assign lplace = 1'b0;
         assign lkey   = req_order_key;
         assign ltag   = req_request_tag;
      end else begin : g_inner
         assign lplace = place[i-1];
         assign lkey   = cell_key[i-1];
         assign ltag   = cell_tag[i-1];
      end

      // The last cell refills from itself on a take; it becomes unoccupied.
      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign rkey = cell_key[i];
         assign rtag = cell_tag[i];
      end else begin : g_mid
         assign rkey = cell_key[i+1];
         assign rtag = cell_tag[i+1];
      end

      srq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (occ),
         .new_key    (req_order_key),
         .new_tag    (req_request_tag),
         .left_place (lplace),
         .left_key   (lkey),
         .left_tag   (ltag),
         .right_key  (rkey),
         .right_tag  (rtag),
         .place      (place[i]),
         .key_ff     (cell_key[i]),
         .tag_ff     (cell_tag[i])
      );
   end

   // Result and fill count for the request at hand.
   always_comb begin
      count_in    = count_ff;
      status_in   = ST_INSERTED;
      head_key_in = '0;
      head_tag_in = '0;
      if (action_type'(req_action) == ACT_INSERT) begin
         if (is_full) begin
            status_in = ST_FULL;
         end else begin
            status_in = ST_INSERTED;
            count_in  = count_ff + COUNT_W'(1);
         end
      end else begin
         if (is_empty) begin
            status_in = ST_EMPTY;
         end else begin
            status_in   = ST_TAKEN;
            head_key_in = cell_key[0];
            head_tag_in = cell_tag[0];
            count_in    = count_ff - COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // Result payload needs no reset; it is qualified by the strobe.
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff   <= status_in;
         head_key_ff <= head_key_in;
         head_tag_ff <= head_tag_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_head_key   = head_key_ff;
   assign rsp_head_tag   = head_tag_ff;
   assign rsp_fill_level = count_ff;

endmodule

// File: tb/sv/srq_order_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted request queue checker
// Watches both channels, keeps its own sorted copy of the queue, and compares
// every result field by field against the oldest expected one.
// ----------------------------------------------------------------------------
module srq_order_checker
   import srq_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic                      req_action,
   input  logic signed [KEY_W-1:0]   req_order_key,
   input  logic        [TAG_W-1:0]   req_request_tag,
   input  logic                      rsp_valid,
   input  logic        [1:0]         rsp_status,
   input  logic signed [KEY_W-1:0]   rsp_head_key,
   input  logic        [TAG_W-1:0]   rsp_head_tag,
   input  logic        [COUNT_W-1:0] rsp_fill_level,
   output int                        failures,
   output int                        outstanding,
   output int                        results_seen,
   output int                        full_refusals,
   output int                        empty_takes
);

   typedef struct packed {
      status_type                status;
      logic signed [KEY_W-1:0]   head_key;
      logic        [TAG_W-1:0]   head_tag;
      logic        [COUNT_W-1:0] fill_level;
   } queue_result_type;

   logic signed [KEY_W-1:0] queued_keys [QUEUE_DEPTH];
   logic        [TAG_W-1:0] queued_tags [QUEUE_DEPTH];
   int                      queued_count;
   queue_result_type        expected_results [$];
   int                      fail_total;
   int                      seen_total;
   int                      full_total;
   int                      empty_total;

   // Applies one request to the sorted copy and returns the result it gives.
   function automatic queue_result_type sort_into_queue(input action_type act,
         input logic signed [KEY_W-1:0] key, input logic [TAG_W-1:0] tag);
      queue_result_type outcome;
      int               pos;
      outcome = '0;
      if (act == ACT_INSERT) begin
         if (queued_count >= QUEUE_DEPTH) begin
            outcome.status = ST_FULL;
         end else begin
            // The new request goes behind every entry whose key is not greater.
            pos = 0;
            while (pos < queued_count && queued_keys[pos] <= key) pos++;
            for (int i = queued_count; i > pos; i--) begin
               queued_keys[i] = queued_keys[i-1];
               queued_tags[i] = queued_tags[i-1];
            end
            queued_keys[pos] = key;
            queued_tags[pos] = tag;
            queued_count++;
            outcome.status = ST_INSERTED;
         end
      end else begin
         if (queued_count == 0) begin
            outcome.status = ST_EMPTY;
         end else begin
            outcome.head_key = queued_keys[0];
            outcome.head_tag = queued_tags[0];
            for (int i = 1; i < queued_count; i++) begin
               queued_keys[i-1] = queued_keys[i];
               queued_tags[i-1] = queued_tags[i];
            end
            queued_count--;
            outcome.status = ST_TAKEN;
         end
      end
      outcome.fill_level = queued_count[COUNT_W-1:0];
      return outcome;
   endfunction

   always @(posedge clock) begin : watch
      queue_result_type wanted;
      if (reset) begin
         queued_count = 0;
         expected_results.delete();
         fail_total  = 0;
         seen_total  = 0;
         full_total  = 0;
         empty_total = 0;
      end else begin
         // Results are checked before the new request is predicted, since a
         // result on this edge always belongs to an earlier request.
         if (rsp_valid) begin
            seen_total++;
            if (expected_results.size() == 0) begin
               $error("Result with no request outstanding: status %0d", rsp_status);
               fail_total++;
            end else begin
               wanted = expected_results.pop_front();
               if (rsp_status !== wanted.status) begin
                  $error("status: expected %0d, actual %0d", wanted.status, rsp_status);
                  fail_total++;
               end
               if (rsp_head_key !== wanted.head_key) begin
                  $error("head_key: expected %0d, actual %0d", wanted.head_key,
                         rsp_head_key);
                  fail_total++;
               end
               if (rsp_head_tag !== wanted.head_tag) begin
                  $error("head_tag: expected %h, actual %h", wanted.head_tag,
                         rsp_head_tag);
                  fail_total++;
               end
               if (rsp_fill_level !== wanted.fill_level) begin
                  $error("fill_level: expected %0d, actual %0d", wanted.fill_level,
                         rsp_fill_level);
                  fail_total++;
               end
            end
         end
         if (start && !busy) begin
            wanted = sort_into_queue(action_type'(req_action), req_order_key,
                                     req_request_tag);
            if (wanted.status == ST_FULL) full_total++;
            if (wanted.status == ST_EMPTY) empty_total++;
            expected_results.push_back(wanted);
         end
      end
      failures      <= fail_total;
      outstanding   <= expected_results.size();
      results_seen  <= seen_total;
      full_refusals <= full_total;
      empty_takes   <= empty_total;
   end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted request queue testbench
// Drives directed and random insert and take requests into the queue with
// varying sender gaps, and lets the checker predict and compare every result.
// ----------------------------------------------------------------------------
module tb;
   import srq_pkg::*;

   localparam int RANDOM_ITEMS = 1250;
   // A correct run never goes this long without a request or a result.
   localparam int QUIET_LIMIT  = 2000;
   localparam logic signed [KEY_W-1:0] KEY_MIN = 64'sh8000_0000_0000_0000;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 64'sh7fff_ffff_ffff_ffff;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic                      req_action;
   logic signed [KEY_W-1:0]   req_order_key;
   logic        [TAG_W-1:0]   req_request_tag;
   logic                      rsp_valid;
   logic        [1:0]         rsp_status;
   logic signed [KEY_W-1:0]   rsp_head_key;
   logic        [TAG_W-1:0]   rsp_head_tag;
   logic        [COUNT_W-1:0] rsp_fill_level;

   int failures;
   int outstanding;
   int results_seen;
   int full_refusals;
   int empty_takes;
   int sent_requests = 0;
   int quiet_cycles  = 0;

   always #10 clock = ~clock;

   sorted_request_queue_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_order_key   (req_order_key),
      .req_request_tag (req_request_tag),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_head_key    (rsp_head_key),
      .rsp_head_tag    (rsp_head_tag),
      .rsp_fill_level  (rsp_fill_level)
   );

   srq_order_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_order_key   (req_order_key),
      .req_request_tag (req_request_tag),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_head_key    (rsp_head_key),
      .rsp_head_tag    (rsp_head_tag),
      .rsp_fill_level  (rsp_fill_level),
      .failures        (failures),
      .outstanding     (outstanding),
      .results_seen    (results_seen),
      .full_refusals   (full_refusals),
      .empty_takes     (empty_takes)
   );

   // The watchdog restarts whenever a request or a result moves; a long quiet
   // stretch means the block has hung or dropped a result.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("sorted_request_queue_top regression: fail");
            $finish;
         end
      end
   end

   // Keys mostly come from a narrow band so that equal keys are common and the
   // first-in first-out order among them gets exercised; the rest are a wider
   // band around zero, fully random patterns and the signed extremes.
   function automatic logic signed [KEY_W-1:0] pick_order_key();
      logic signed [KEY_W-1:0] value;
      int                      pick;
      pick = $urandom_range(9, 0);
      if (pick < 5) begin
         value = KEY_W'($urandom_range(7, 0));
         value = value - 64'sd4;
      end else if (pick < 8) begin
         value = {$urandom, $urandom};
      end else if (pick == 8) begin
         case ($urandom_range(3, 0))
            0: value = KEY_MIN;
            1: value = KEY_MAX;
            2: value = '0;
            default: value = '1;
         endcase
      end else begin
         value = KEY_W'($urandom_range(255, 0));
         value = value - 64'sd128;
      end
      return value;
   endfunction

   // Sends one request. The sender's idle rate follows the run's phase: a third
   // of the run at 34 percent gaps, a third at 55 percent, then back to back.
   task automatic send_request(input action_type act, input logic signed [KEY_W-1:0] key,
                               input logic [TAG_W-1:0] tag);
      int idle_pct;
      if (sent_requests < (RANDOM_ITEMS + 25) / 3)
         idle_pct = 34;
      else if (sent_requests < 2 * (RANDOM_ITEMS + 25) / 3)
         idle_pct = 55;
      else
         idle_pct = 0;
      while ($urandom_range(99, 0) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start           <= 1'b1;
      req_action      <= act;
      req_order_key   <= key;
      req_request_tag <= tag;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent_requests++;
   endtask

   initial begin
      int burst_len;
      int insert_pct;
      int random_sent;
      reset           <= 1'b1;
      start           <= 1'b0;
      req_action      <= ACT_INSERT;
      req_order_key   <= '0;
      req_request_tag <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A take on the empty queue, with its unused fields set,
      // must report empty and return zeros.
      send_request(ACT_TAKE, '1, 16'hffff);
      // Signed extremes and the keys around zero, then three equal keys that
      // must leave in arrival order.
      send_request(ACT_INSERT, KEY_MAX, 16'h0001);
      send_request(ACT_INSERT, KEY_MIN, 16'hffff);
      send_request(ACT_INSERT, '0, 16'h0000);
      send_request(ACT_INSERT, '1, 16'h1234);
      send_request(ACT_INSERT, 64'sd5, 16'h000a);
      send_request(ACT_INSERT, 64'sd5, 16'h000b);
      send_request(ACT_INSERT, 64'sd5, 16'h000c);
      send_request(ACT_TAKE, KEY_MAX, 16'h5a5a);
      // Fill the queue to its depth, then try one insert too many.
      send_request(ACT_INSERT, 64'sd5, 16'h000d);
      send_request(ACT_INSERT, '1, 16'h4321);
      for (int i = 0; i < QUEUE_DEPTH - 8; i++)
         send_request(ACT_INSERT, pick_order_key(), 16'($urandom_range(65535, 0)));
      send_request(ACT_INSERT, '0, 16'hbeef);
      repeat (4) send_request(ACT_TAKE, '0, 16'h0000);

      // Random part in bursts, each biased toward inserts, takes or neither,
      // so the queue keeps swinging between empty and full.
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         burst_len = $urandom_range(40, 8);
         case ($urandom_range(2, 0))
            0: insert_pct = 15;
            1: insert_pct = 50;
            default: insert_pct = 85;
         endcase
         for (int j = 0; j < burst_len; j++) begin
            send_request(($urandom_range(99, 0) < insert_pct) ? ACT_INSERT : ACT_TAKE,
                         pick_order_key(), 16'($urandom_range(65535, 0)));
            random_sent++;
         end
      end
      start <= 1'b0;

      // Let every result drain, then keep the clock running to catch strays.
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Sent %0d insert and take requests and checked %0d results.",
               sent_requests, results_seen);
      $display("The queue refused %0d inserts as full and saw %0d takes while empty.",
               full_refusals, empty_takes);
      if (failures == 0) begin
         $display("sorted_request_queue_top regression: pass");
      end else begin
         $display("sorted_request_queue_top regression: fail");
      end
      $finish;
   end

endmodule
